### hdl/rv32ie_pkg.sv
`timescale 1ns / 1ps

package rv32ie_pkg;

    localparam int C_MEM_WORDS = 1024;
    localparam int C_UPPER_SH  = 12;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_SUB   = 6'd1;
    localparam logic [5:0] OP_SLL   = 6'd2;
    localparam logic [5:0] OP_SLT   = 6'd3;
    localparam logic [5:0] OP_SLTU  = 6'd4;
    localparam logic [5:0] OP_XOR   = 6'd5;
    localparam logic [5:0] OP_SRL   = 6'd6;
    localparam logic [5:0] OP_SRA   = 6'd7;
    localparam logic [5:0] OP_OR    = 6'd8;
    localparam logic [5:0] OP_AND   = 6'd9;
    localparam logic [5:0] OP_ADDI  = 6'd10;
    localparam logic [5:0] OP_SLTI  = 6'd11;
    localparam logic [5:0] OP_SLTIU = 6'd12;
    localparam logic [5:0] OP_XORI  = 6'd13;
    localparam logic [5:0] OP_ORI   = 6'd14;
    localparam logic [5:0] OP_ANDI  = 6'd15;
    localparam logic [5:0] OP_SLLI  = 6'd16;
    localparam logic [5:0] OP_SRLI  = 6'd17;
    localparam logic [5:0] OP_SRAI  = 6'd18;
    localparam logic [5:0] OP_LUI   = 6'd19;
    localparam logic [5:0] OP_AUIPC = 6'd20;
    localparam logic [5:0] OP_JAL   = 6'd21;
    localparam logic [5:0] OP_JALR  = 6'd22;
    localparam logic [5:0] OP_BEQ   = 6'd23;
    localparam logic [5:0] OP_BNE   = 6'd24;
    localparam logic [5:0] OP_BLT   = 6'd25;
    localparam logic [5:0] OP_BGE   = 6'd26;
    localparam logic [5:0] OP_BLTU  = 6'd27;
    localparam logic [5:0] OP_BGEU  = 6'd28;
    localparam logic [5:0] OP_LB    = 6'd29;
    localparam logic [5:0] OP_LH    = 6'd30;
    localparam logic [5:0] OP_LW    = 6'd31;
    localparam logic [5:0] OP_LBU   = 6'd32;
    localparam logic [5:0] OP_LHU   = 6'd33;
    localparam logic [5:0] OP_SB    = 6'd34;
    localparam logic [5:0] OP_SH    = 6'd35;
    localparam logic [5:0] OP_SW    = 6'd36;
    localparam logic [5:0] OP_HALT  = 6'd37;

    typedef struct packed {
        logic [5:0]         op;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] imm;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
        logic        mem_write;
        logic        branch_taken;
        logic        halted;
    } t_out_item;

    typedef enum logic [3:0] {
        K_ALU, K_LUI, K_AUIPC, K_JAL, K_JALR, K_BR, K_LOAD, K_STORE, K_HALT, K_NOP
    } t_kind;

    typedef enum logic [3:0] {
        A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU, A_XOR, A_SRL, A_SRA, A_OR, A_AND
    } t_alu;

    typedef enum logic [2:0] {
        C_EQ, C_NE, C_LT, C_GE, C_LTU, C_GEU
    } t_cond;

    typedef enum logic [2:0] {
        L_B, L_H, L_W, L_BU, L_HU
    } t_lsz;

    typedef enum logic [1:0] {
        S_B, S_H, S_W
    } t_ssz;

    typedef struct packed {
        t_kind       kind;
        t_alu        alu;
        logic        use_imm;
        t_cond       cond;
        t_lsz        lsz;
        t_ssz        ssz;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
    } t_dec;

    typedef struct packed {
        logic vld;
        t_dec dec;
    } t_qhead;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_bk_stat;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        wb;
        logic [4:0]  rd;
        logic [31:0] val;
        logic        mw;
        logic        taken;
        logic        halted;
        logic        ld;
        t_lsz        lsz;
        t_ssz        ssz;
        logic [31:0] sdata;
        logic [31:0] addr;
    } t_ex;

endpackage

### hdl/rv32ie_front.sv
`timescale 1ns / 1ps

module rv32ie_front
    import rv32ie_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    input  t_bk_stat i_bk_stat,
    output t_qhead   o_head
);

    localparam logic [1:0] Q_FULL = 2'd2;

    t_dec       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    t_dec       dec;
    logic       push, pop;

    always_comb begin
        dec         = '0;
        dec.kind    = K_NOP;
        dec.alu     = A_ADD;
        dec.use_imm = 1'b0;
        dec.cond    = C_EQ;
        dec.lsz     = L_W;
        dec.ssz     = S_W;
        dec.rd      = i_in_item.dest_reg;
        dec.rs1     = i_in_item.src1_reg;
        dec.rs2     = i_in_item.src2_reg;
        dec.imm     = i_in_item.imm;
        if (i_in_item.op <= OP_AND) begin
            dec.kind = K_ALU;
            dec.alu  = t_alu'(i_in_item.op[3:0]);
        end else if (i_in_item.op <= OP_SRAI) begin
            dec.kind    = K_ALU;
            dec.use_imm = 1'b1;
            case (i_in_item.op)
                OP_ADDI:  dec.alu = A_ADD;
                OP_SLTI:  dec.alu = A_SLT;
                OP_SLTIU: dec.alu = A_SLTU;
                OP_XORI:  dec.alu = A_XOR;
                OP_ORI:   dec.alu = A_OR;
                OP_ANDI:  dec.alu = A_AND;
                OP_SLLI:  dec.alu = A_SLL;
                OP_SRLI:  dec.alu = A_SRL;
                default:  dec.alu = A_SRA;
            endcase
        end else begin
            case (i_in_item.op)
                OP_LUI:   dec.kind = K_LUI;
                OP_AUIPC: dec.kind = K_AUIPC;
                OP_JAL:   dec.kind = K_JAL;
                OP_JALR:  dec.kind = K_JALR;
                OP_BEQ: begin dec.kind = K_BR; dec.cond = C_EQ;  end
                OP_BNE: begin dec.kind = K_BR; dec.cond = C_NE;  end
                OP_BLT: begin dec.kind = K_BR; dec.cond = C_LT;  end
                OP_BGE: begin dec.kind = K_BR; dec.cond = C_GE;  end
                OP_BLTU: begin dec.kind = K_BR; dec.cond = C_LTU; end
                OP_BGEU: begin dec.kind = K_BR; dec.cond = C_GEU; end
                OP_LB:  begin dec.kind = K_LOAD; dec.lsz = L_B;  end
                OP_LH:  begin dec.kind = K_LOAD; dec.lsz = L_H;  end
                OP_LW:  begin dec.kind = K_LOAD; dec.lsz = L_W;  end
                OP_LBU: begin dec.kind = K_LOAD; dec.lsz = L_BU; end
                OP_LHU: begin dec.kind = K_LOAD; dec.lsz = L_HU; end
                OP_SB:  begin dec.kind = K_STORE; dec.ssz = S_B; end
                OP_SH:  begin dec.kind = K_STORE; dec.ssz = S_H; end
                OP_SW:  begin dec.kind = K_STORE; dec.ssz = S_W; end
                OP_HALT: dec.kind = K_HALT;
                default: dec.kind = K_NOP;
            endcase
        end
    end

    // hold off while full or while the back end clears its memory
    assign o_in_stall = (r_cnt == Q_FULL) || i_bk_stat.busy;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_bk_stat.pop;

    assign o_head.vld = (r_cnt != 2'd0);
    assign o_head.dec = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### hdl/rv32ie_back.sv
`timescale 1ns / 1ps

module rv32ie_back
    import rv32ie_pkg::*;
#(
    parameter int MEM_WORDS = C_MEM_WORDS
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_qhead    i_head,
    output t_bk_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int RW = AW + 1;
    localparam logic [31:0]   RECIP   = 32'(64'h1_0000_0000 / 64'(MEM_WORDS));
    localparam logic [RW-1:0] MW_R    = RW'(MEM_WORDS);
    localparam logic [AW-1:0] CLR_END = AW'(MEM_WORDS - 1);

    // register file and data memory
    logic [31:0]   r_rf [32];
    logic [31:0]   r_rf_vld;
    logic [31:0]   r_mem [MEM_WORDS];
    logic [31:0]   r_rd1, r_rd2, r_mdata;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_cnt;

    // architectural state
    logic [31:0] r_pc;
    logic        r_halt;

    // pipeline
    logic          r_e1_vld, r_m1_vld, r_m2_vld, r_e2_vld, r_out_vld;
    t_dec          r_e1;
    t_ex           r_m1, r_m2, r_e2;
    logic [31:0]   r_m2_q;
    logic [AW-1:0] r_e2_idx;
    t_out_item     r_out;

    logic out_free, e2_go, e2_free, m2_go, m2_free, m1_go, m1_free, e1_go, e1_free, pop;
    logic [4:0]    ra1, ra2;
    logic [31:0]   e2_wbval, e2_word_st;
    logic [31:0]   op_a, op_b, alu_b, pc4;
    logic          haz;
    t_ex           ex;
    logic [63:0]   m1_prod;
    logic [RW-1:0] m2_qm, m2_rem;
    logic [AW-1:0] m2_idx, mem_ra, mem_wa;
    logic          mem_we, wb_we;
    logic [31:0]   mem_wd;

    function automatic logic [31:0] alu_f(t_alu sel, logic [31:0] a, logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (sel)
            A_ADD:   return a + b;
            A_SUB:   return a - b;
            A_SLL:   return a << sh;
            A_SLT:   return {31'b0, $signed(a) < $signed(b)};
            A_SLTU:  return {31'b0, a < b};
            A_XOR:   return a ^ b;
            A_SRL:   return a >> sh;
            A_SRA:   return 32'($signed(a) >>> sh);
            A_OR:    return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] ld_fmt(t_lsz sz, logic [31:0] w);
        case (sz)
            L_B:     return {{24{w[7]}}, w[7:0]};
            L_H:     return {{16{w[15]}}, w[15:0]};
            L_BU:    return {24'b0, w[7:0]};
            L_HU:    return {16'b0, w[15:0]};
            default: return w;
        endcase
    endfunction

    function automatic logic hit(logic vld, t_ex s, logic [4:0] rs);
        return vld && s.wb && (s.rd == rs);
    endfunction

    // handshake between stages
    assign out_free = !r_out_vld || !i_out_stall;
    assign e2_go    = r_e2_vld && out_free;
    assign e2_free  = !r_e2_vld || out_free;
    assign m2_go    = r_m2_vld && e2_free;
    assign m2_free  = !r_m2_vld || e2_free;
    assign m1_go    = r_m1_vld && m2_free;
    assign m1_free  = !r_m1_vld || m2_free;
    assign e1_go    = r_e1_vld && !haz && m1_free;
    assign e1_free  = !r_e1_vld || e1_go;
    assign pop      = i_head.vld && e1_free && !r_clr_busy;

    assign o_stat.pop  = pop;
    assign o_stat.busy = r_clr_busy;

    // E2 results
    assign e2_wbval = r_e2.ld ? ld_fmt(r_e2.lsz, r_mdata) : r_e2.val;
    always_comb begin
        case (r_e2.ssz)
            S_B:     e2_word_st = {r_mdata[31:8], r_e2.sdata[7:0]};
            S_H:     e2_word_st = {r_mdata[31:16], r_e2.sdata[15:0]};
            default: e2_word_st = r_e2.sdata;
        endcase
    end

    // register file: re-read each cycle for the item in E1, write-first
    assign ra1   = pop ? i_head.dec.rs1 : r_e1.rs1;
    assign ra2   = pop ? i_head.dec.rs2 : r_e1.rs2;
    assign wb_we = e2_go && r_e2.wb;

    always_ff @(posedge i_clk) begin
        if (wb_we) begin
            r_rf[r_e2.rd] <= e2_wbval;
        end
        if (wb_we && r_e2.rd == ra1) begin
            r_rd1 <= e2_wbval;
        end else begin
            r_rd1 <= r_rf_vld[ra1] ? r_rf[ra1] : 32'd0;
        end
        if (wb_we && r_e2.rd == ra2) begin
            r_rd2 <= e2_wbval;
        end else begin
            r_rd2 <= r_rf_vld[ra2] ? r_rf[ra2] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wb_we) begin
            r_rf_vld[r_e2.rd] <= 1'b1;
        end
    end

    // E1: forward from later stages; a load still in M1 or M2 holds E1
    always_comb begin
        if (hit(r_m1_vld, r_m1, r_e1.rs1)) begin
            op_a = r_m1.val;
        end else if (hit(r_m2_vld, r_m2, r_e1.rs1)) begin
            op_a = r_m2.val;
        end else if (hit(r_e2_vld, r_e2, r_e1.rs1)) begin
            op_a = e2_wbval;
        end else begin
            op_a = r_rd1;
        end
        if (hit(r_m1_vld, r_m1, r_e1.rs2)) begin
            op_b = r_m1.val;
        end else if (hit(r_m2_vld, r_m2, r_e1.rs2)) begin
            op_b = r_m2.val;
        end else if (hit(r_e2_vld, r_e2, r_e1.rs2)) begin
            op_b = e2_wbval;
        end else begin
            op_b = r_rd2;
        end
        haz = (r_m1.ld && (hit(r_m1_vld, r_m1, r_e1.rs1) || hit(r_m1_vld, r_m1, r_e1.rs2)))
            || (r_m2.ld && (hit(r_m2_vld, r_m2, r_e1.rs1)
                            || hit(r_m2_vld, r_m2, r_e1.rs2)));
    end

    assign alu_b = r_e1.use_imm ? r_e1.imm : op_b;
    assign pc4   = r_pc + 32'd4;

    always_comb begin
        ex         = '0;
        ex.next_pc = pc4;
        ex.rd      = r_e1.rd;
        ex.lsz     = r_e1.lsz;
        ex.ssz     = r_e1.ssz;
        ex.sdata   = op_b;
        ex.addr    = op_a + r_e1.imm;
        case (r_e1.kind)
            K_ALU: begin
                ex.val = alu_f(r_e1.alu, op_a, alu_b);
                ex.wb  = 1'b1;
            end
            K_LUI: begin
                ex.val = r_e1.imm << C_UPPER_SH;
                ex.wb  = 1'b1;
            end
            K_AUIPC: begin
                ex.val = r_pc + (r_e1.imm << C_UPPER_SH);
                ex.wb  = 1'b1;
            end
            K_JAL: begin
                ex.val     = pc4;
                ex.wb      = 1'b1;
                ex.next_pc = r_pc + r_e1.imm;
                ex.taken   = 1'b1;
            end
            K_JALR: begin
                ex.val     = pc4;
                ex.wb      = 1'b1;
                ex.next_pc = {ex.addr[31:1], 1'b0};
                ex.taken   = 1'b1;
            end
            K_BR: begin
                case (r_e1.cond)
                    C_EQ:    ex.taken = (op_a == op_b);
                    C_NE:    ex.taken = (op_a != op_b);
                    C_LT:    ex.taken = ($signed(op_a) < $signed(op_b));
                    C_GE:    ex.taken = !($signed(op_a) < $signed(op_b));
                    C_LTU:   ex.taken = (op_a < op_b);
                    default: ex.taken = (op_a >= op_b);
                endcase
                if (ex.taken) begin
                    ex.next_pc = r_pc + r_e1.imm;
                end
            end
            K_LOAD: begin
                ex.wb = 1'b1;
                ex.ld = 1'b1;
            end
            K_STORE: ex.mw = 1'b1;
            K_HALT:  ex.halted = 1'b1;
            default: ex.wb = 1'b0;
        endcase
        // drop writes to x0
        if (ex.rd == 5'd0) begin
            ex.wb = 1'b0;
            ex.ld = 1'b0;
        end
        if (!ex.wb) begin
            ex.rd  = 5'd0;
            ex.val = 32'd0;
        end
        if (r_halt || r_e1.kind == K_HALT) begin
            ex         = '0;
            ex.lsz     = L_W;
            ex.ssz     = S_W;
            ex.next_pc = r_pc;
            ex.halted  = 1'b1;
        end
    end

    // M1: approximate quotient of the address by the memory size
    assign m1_prod = 64'(r_m1.addr) * 64'(RECIP);

    // M2: remainder, one correction step, memory read
    assign m2_qm  = r_m2_q[RW-1:0] * MW_R;
    assign m2_rem = r_m2.addr[RW-1:0] - m2_qm;
    assign m2_idx = (m2_rem >= MW_R) ? AW'(m2_rem - MW_R) : AW'(m2_rem);

    // re-read the E2 item's word while it waits
    assign mem_ra = m2_go ? m2_idx : r_e2_idx;
    assign mem_we = r_clr_busy || (e2_go && r_e2.mw);
    assign mem_wa = r_clr_busy ? r_clr_cnt : r_e2_idx;
    assign mem_wd = r_clr_busy ? 32'd0 : e2_word_st;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_we && mem_wa == mem_ra) begin
            r_mdata <= mem_wd;
        end else begin
            r_mdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
            if (r_clr_cnt == CLR_END) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_e1 <= i_head.dec;
        end
        if (e1_go) begin
            r_m1 <= ex;
        end
        if (m1_go) begin
            r_m2   <= r_m1;
            r_m2_q <= m1_prod[63:32];
        end
        if (m2_go) begin
            r_e2     <= r_m2;
            r_e2_idx <= m2_idx;
        end
        if (e2_go) begin
            r_out.next_pc      <= r_e2.next_pc;
            r_out.wb_valid     <= r_e2.wb;
            r_out.wb_reg       <= r_e2.rd;
            r_out.wb_value     <= r_e2.wb ? e2_wbval : 32'd0;
            r_out.mem_write    <= r_e2.mw;
            r_out.branch_taken <= r_e2.taken;
            r_out.halted       <= r_e2.halted;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld  <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_e2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= 32'd0;
            r_halt    <= 1'b0;
        end else begin
            if (e1_free) begin
                r_e1_vld <= pop;
            end
            if (m1_free) begin
                r_m1_vld <= e1_go;
            end
            if (m2_free) begin
                r_m2_vld <= m1_go;
            end
            if (e2_free) begin
                r_e2_vld <= m2_go;
            end
            if (out_free) begin
                r_out_vld <= e2_go;
            end
            if (e1_go) begin
                r_pc   <= ex.next_pc;
                r_halt <= ex.halted;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_idle_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_e1_vld && !r_m1_vld && !r_m2_vld && !r_e2_vld))
        else $error("pipeline busy during memory clear");

    a_x0_never_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_vld[0])
        else $error("x0 marked written");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m2_vld |-> ({1'b0, m2_idx} < MW_R))
        else $error("memory index out of range");

    a_halt_is_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e1_go && r_halt) |=> (r_m1.halted && !r_m1.wb && !r_m1.mw))
        else $error("item after halt has side effects");

    a_clear_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_cnt) == CLR_END))
        else $error("memory clear ended early");
`endif

endmodule

### hdl/rv32i_instruction_execute_core.sv
`timescale 1ns / 1ps

// RV32I execute core. Each input item is one decoded instruction; each one
// gives exactly one result item, in order.
// Input channel: i_in_valid / o_in_stall / i_in_item. Output channel:
// o_out_valid / i_out_stall / o_out_item. An item moves at a clock edge where
// valid is high and stall is low.
// A front end decodes items into a two-entry queue; the back end pipeline
// (execute, two address-reduction stages, memory/writeback, output register)
// pulls from it, so the input keeps flowing while the output is stalled until the pipeline and queue are full.
// Throughput: one item per cycle while the output is not stalled. An item
// that reads the destination of a load one or two items ahead waits in E1
// until the load has left M2 and its data can be forwarded from E2.
// Reset (i_rst_n low at a clock edge): registers, PC and halt state clear,
// then the data memory is zeroed at one word per cycle, all MEM_WORDS words,
// with o_in_stall held high throughout.
// While i_out_stall is high the output item holds; the pipeline and then the
// queue fill, after which o_in_stall rises.
// After a halt every later item leaves state untouched and reports halted.
module rv32i_instruction_execute_core
    import rv32ie_pkg::*;
#(
    parameter int MEM_WORDS = C_MEM_WORDS
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_qhead   head;
    t_bk_stat bk_stat;

    rv32ie_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_bk_stat  (bk_stat),
        .o_head     (head)
    );

    rv32ie_back #(
        .MEM_WORDS (MEM_WORDS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_stat      (bk_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
